// ===== rtl/core/gcrm_pkg.sv =====
// Shared types, constants and helper functions of the conserved residue marker.
package gcrm_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int LETTERS      = 26;
  localparam int CODE_W       = 5;
  localparam int COUNT_W      = 7;
  localparam int OSUM_W       = 12;
  localparam int PROD_W       = 14;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 26;

  localparam logic [CODE_W-1:0]  NOT_LETTER = CODE_W'(LETTERS);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_ROWS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_LEVEL_PCT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LEVEL_PCT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIM_ENABLE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIM_SET_MASK    = 3'd4;

  typedef struct packed {
    logic [7:0] residue;
    logic       in_group;
    logic       column_end;
  } in_beat_t;

  typedef struct packed {
    logic [5:0] row_index;
    logic       marked;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic accept;
    logic scan_init;
    logic scan_step;
    logic decide;
    logic rd;
    logic advance;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic rows_zero;
    logic last;
  } status_t;

  // Folds case and maps A..Z to 0..25; everything else becomes NOT_LETTER.
  function automatic logic [CODE_W-1:0] letter_code(input logic [7:0] ch);
    logic [7:0] diff;
    begin
      diff = 8'h00;
      if (ch inside {[8'h61:8'h7a]}) begin
        diff = ch - 8'h61;
        letter_code = diff[CODE_W-1:0];
      end else if (ch inside {[8'h41:8'h5a]}) begin
        diff = ch - 8'h41;
        letter_code = diff[CODE_W-1:0];
      end else begin
        letter_code = NOT_LETTER;
      end
    end
  endfunction

endpackage

// ===== rtl/core/gcrm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gcrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/gcrm_datapath.sv =====
// Datapath: letter counters, row letter store, column scan, thresholds and results.
module gcrm_datapath
  import gcrm_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_beat_t              in_data,
  input  cmd_t                  cmd,
  output status_t               status,
  output out_beat_t             out_data
);

  localparam int AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W = $clog2(MAX_ROWS + 1);

  // Configuration registers.
  logic [6:0]         group_rows;
  logic [6:0]         group_level_pct;
  logic [6:0]         out_level_pct;
  logic               sim_enable;
  logic [LETTERS-1:0] sim_set_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_rows      <= 7'd1;
      group_level_pct <= 7'd50;
      out_level_pct   <= 7'd0;
      sim_enable      <= 1'b0;
      sim_set_mask    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GROUP_ROWS:      group_rows      <= cfg_data[6:0];
        REG_GROUP_LEVEL_PCT: group_level_pct <= cfg_data[6:0];
        REG_OUT_LEVEL_PCT:   out_level_pct   <= cfg_data[6:0];
        REG_SIM_ENABLE:      sim_enable      <= cfg_data[0];
        REG_SIM_SET_MASK:    sim_set_mask    <= cfg_data[LETTERS-1:0];
        default: ;
      endcase
    end
  end

  // Accumulation of one column.
  logic [COUNT_W-1:0] gcnt [LETTERS];
  logic [COUNT_W-1:0] ocnt [LETTERS];
  logic [CNT_W-1:0]   row_cnt;
  logic [CODE_W-1:0]  in_code;
  logic               in_is_letter;
  logic               row_room;
  logic               ram_we;

  assign in_code      = letter_code(in_data.residue);
  assign in_is_letter = in_code < NOT_LETTER;
  assign row_room     = row_cnt < CNT_W'(MAX_ROWS);
  assign ram_we       = cmd.accept && in_data.in_group && row_room;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < LETTERS; i++) begin
        gcnt[i] <= '0;
        ocnt[i] <= '0;
      end
      row_cnt <= '0;
    end else if (cmd.accept) begin
      if (in_data.in_group) begin
        if (row_room) begin
          row_cnt <= row_cnt + 1'b1;
          if (in_is_letter && gcnt[in_code] != COUNT_MAX) begin
            gcnt[in_code] <= gcnt[in_code] + 1'b1;
          end
        end
      end else if (in_is_letter && ocnt[in_code] != COUNT_MAX) begin
        ocnt[in_code] <= ocnt[in_code] + 1'b1;
      end
    end
  end

  // Column scan, one letter per cycle. Two best candidates are tracked: one over
  // all letters and one over letters outside the similarity set, because which
  // one counts is only known once the set's presence has been tallied.
  logic [CODE_W-1:0]  scan_idx;
  logic [COUNT_W-1:0] total;
  logic [CODE_W-1:0]  present;
  logic [COUNT_W-1:0] set_sum;
  logic [OSUM_W-1:0]  oset_sum;
  logic [COUNT_W-1:0] all_c, ns_c, all_o, ns_o;
  logic [CODE_W-1:0]  all_k, ns_k;
  logic [PROD_W-1:0]  need_prod, lim_prod;
  logic [COUNT_W-1:0] g_cur, o_cur;
  logic               s_cur;

  assign g_cur = gcnt[scan_idx];
  assign o_cur = ocnt[scan_idx];
  assign s_cur = sim_set_mask[scan_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (cmd.scan_init) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      total    <= '0;
      present  <= '0;
      set_sum  <= '0;
      oset_sum <= '0;
      all_c    <= '0;
      all_k    <= '0;
      all_o    <= '0;
      ns_c     <= '0;
      ns_k     <= '0;
      ns_o     <= '0;
    end else if (cmd.scan_step) begin
      total <= total + g_cur;
      // Other-row hits count for every set letter, present in the group or not.
      if (s_cur) begin
        oset_sum <= oset_sum + OSUM_W'(o_cur);
      end
      if (s_cur && g_cur != '0) begin
        present  <= present + 1'b1;
        set_sum  <= set_sum + g_cur;
      end
      if (g_cur > all_c) begin
        all_c <= g_cur;
        all_k <= scan_idx;
        all_o <= o_cur;
      end
      if (!s_cur && g_cur > ns_c) begin
        ns_c <= g_cur;
        ns_k <= scan_idx;
        ns_o <= o_cur;
      end
    end
  end

  // The products carry the +50 of the half-up rounding.
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      need_prod <= PROD_W'(group_rows) * PROD_W'(group_level_pct) + PROD_W'(50);
      lim_prod  <= PROD_W'(group_rows) * PROD_W'(out_level_pct) + PROD_W'(50);
    end
  end

  // Winner choice and threshold test. Rounded thresholds are compared without a
  // divide: w >= floor(x/100) holds exactly when 100*w + 99 >= x.
  logic               use_set, win_set, pass, pass_next;
  logic [COUNT_W-1:0] best_c, best_o, win_count;
  logic [CODE_W-1:0]  best_k;
  logic [OSUM_W-1:0]  other_sum;
  logic [PROD_W-1:0]  win_scaled;
  logic [18:0]        oth_scaled;
  logic [LETTERS-1:0] win_mask, win_mask_next;

  always_comb begin
    use_set       = sim_enable && (present >= CODE_W'(2));
    best_c        = use_set ? ns_c : all_c;
    best_k        = use_set ? ns_k : all_k;
    best_o        = use_set ? ns_o : all_o;
    win_set       = use_set && (set_sum > best_c);
    win_count     = win_set ? set_sum : best_c;
    other_sum     = win_set ? oset_sum : OSUM_W'(best_o);
    win_scaled    = PROD_W'(win_count) * PROD_W'(100) + PROD_W'(99);
    oth_scaled    = 19'(other_sum) * 19'd100;
    pass_next     = (total != '0) && (win_scaled >= need_prod)
                    && (oth_scaled <= 19'(lim_prod));
    win_mask_next = win_set ? sim_set_mask : (LETTERS'(1) << best_k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass <= 1'b0;
    end else if (cmd.decide) begin
      pass <= pass_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      win_mask <= win_mask_next;
    end
  end

  // Result emission, one group row per read of the letter store.
  logic [CNT_W-1:0]   emit_k;
  logic [CODE_W-1:0]  row_code;
  logic [LETTERS-1:0] mask_sh;

  always_ff @(posedge clk) begin
    if (rst || cmd.decide) begin
      emit_k <= '0;
    end else if (cmd.advance) begin
      emit_k <= emit_k + 1'b1;
    end
  end

  gcrm_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_ROWS)
  ) u_row_letters (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_cnt[AW-1:0]),
    .wdata (in_code),
    .re    (cmd.rd),
    .raddr (emit_k[AW-1:0]),
    .rdata (row_code)
  );

  assign mask_sh = win_mask >> row_code;

  always_comb begin
    out_data.row_index = 6'(emit_k);
    out_data.marked    = pass && (row_code < NOT_LETTER) && mask_sh[0];
    out_data.last      = status.last;
  end

  assign status.scan_last = scan_idx == CODE_W'(LETTERS - 1);
  assign status.rows_zero = row_cnt == '0;
  assign status.last      = (emit_k + 1'b1) == row_cnt;

endmodule

// ===== rtl/core/gcrm_ctrl.sv =====
// Controller: sequences accumulation, column scan, decision and result emission.
module gcrm_ctrl
  import gcrm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_end,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_ACCUM    = 5'b00001,
    S_SCAN     = 5'b00010,
    S_DECIDE   = 5'b00100,
    S_EMIT_RD  = 5'b01000,
    S_EMIT_OUT = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_ACCUM: begin
        in_ready      = 1'b1;
        cmd.accept    = in_valid;
        cmd.scan_init = in_valid && in_end;
        if (in_valid && in_end) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        // A column without group rows produces no results at all.
        if (status.rows_zero) begin
          cmd.clear  = 1'b1;
          state_next = S_ACCUM;
        end else begin
          state_next = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          if (status.last) begin
            cmd.clear  = 1'b1;
            state_next = S_ACCUM;
          end else begin
            state_next = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_ACCUM;
      end
    endcase
  end

endmodule

// ===== rtl/core/group_conserved_residue_marker_unit.sv =====
// Top level of the group conserved residue marker: controller plus datapath.
//
// Residues of one alignment column are taken one beat per cycle; each group row
// keeps its letter in a row store and both group and other rows bump saturating
// per-letter counts. The beat flagged column_end starts a scan of the 26 letter
// counters, one letter a cycle, followed by a decision state that picks the
// winner and tests the two rounded percent thresholds. The block then emits one
// result beat per group row (up to MAX_ROWS), each with a row store read state
// followed by an output state that holds while the output is stalled.
// No input beat is accepted from the column's last residue until all of its
// results have been emitted.
// Configuration writes are always accepted and must be made while idle.
module group_conserved_residue_marker_unit
  import gcrm_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  gcrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_end    (in_data.column_end),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  gcrm_datapath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ===== tb/gcrm_mark_check_pkg.sv =====
// Column predictor and result scoreboard for the conserved residue marker testbench.
package gcrm_mark_check_pkg;
  import gcrm_pkg::*;

  localparam int MARK_ROWS  = DEF_MAX_ROWS;
  localparam int NON_LETTER = LETTERS;
  localparam int SHOW_LIMIT = 10;

  // Case-folded letter index 0..25, or NON_LETTER for anything else.
  function automatic int fold_letter(logic [7:0] ch);
    logic [7:0] up;
    up = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
    if (up >= "A" && up <= "Z") return int'(up - "A");
    return NON_LETTER;
  endfunction

  class mark_scoreboard;
    logic [6:0]  rows_cfg;
    logic [6:0]  grp_pct;
    logic [6:0]  oth_pct;
    logic        sim_on;
    logic [25:0] sim_mask;

    logic [6:0]  grp_count[LETTERS];
    logic [6:0]  oth_count[LETTERS];
    int          row_letter[MARK_ROWS];
    int          rows_seen;

    out_beat_t   expected_marks[$];
    int          mismatches;
    int          residues;
    int          columns;
    int          marks_checked;
    int          marked_rows;

    function new();
      rows_cfg = 7'd1;
      grp_pct = 7'd50;
      oth_pct = 7'd0;
      sim_on = 1'b0;
      sim_mask = '0;
      foreach (grp_count[k]) begin
        grp_count[k] = '0;
        oth_count[k] = '0;
      end
      rows_seen = 0;
      mismatches = 0;
      residues = 0;
      columns = 0;
      marks_checked = 0;
      marked_rows = 0;
    endfunction

    function int pending();
      return expected_marks.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GROUP_ROWS:      rows_cfg = data[6:0];
        REG_GROUP_LEVEL_PCT: grp_pct = data[6:0];
        REG_OUT_LEVEL_PCT:   oth_pct = data[6:0];
        REG_SIM_ENABLE:      sim_on = data[0];
        REG_SIM_SET_MASK:    sim_mask = data[25:0];
        default: ;
      endcase
    endfunction

    // Takes in one residue beat; on column end, decides the winner and queues one
    // result per group row.
    function void note_residue(in_beat_t b);
      int          code;
      int          best;
      int          best_k;
      int          present;
      int          set_sum;
      int          total;
      int          win_count;
      int          other_sum;
      int          need;
      int          limit;
      logic [25:0] win_mask;
      bit          use_set;
      bit          pass;
      out_beat_t   e;

      residues++;
      code = fold_letter(b.residue);
      if (b.in_group) begin
        if (rows_seen < MARK_ROWS) begin
          row_letter[rows_seen] = code;
          if (code < LETTERS && grp_count[code] != COUNT_MAX) grp_count[code]++;
          rows_seen++;
        end
      end else if (code < LETTERS && oth_count[code] != COUNT_MAX) begin
        oth_count[code]++;
      end
      if (!b.column_end) return;

      total = 0;
      present = 0;
      set_sum = 0;
      for (int k = 0; k < LETTERS; k++) begin
        total += grp_count[k];
        if (sim_mask[k] && grp_count[k] != 0) begin
          present++;
          set_sum += grp_count[k];
        end
      end
      use_set = sim_on && present >= 2;

      // Set letters drop out of the single-letter race while the set competes.
      best = 0;
      best_k = 0;
      for (int k = 0; k < LETTERS; k++) begin
        if (!(use_set && sim_mask[k]) && grp_count[k] > best) begin
          best = grp_count[k];
          best_k = k;
        end
      end

      if (use_set && set_sum > best) begin
        win_mask = sim_mask;
        win_count = set_sum;
      end else begin
        win_mask = 26'd1 << best_k;
        win_count = best;
      end

      other_sum = 0;
      for (int k = 0; k < LETTERS; k++) begin
        if (win_mask[k]) other_sum += oth_count[k];
      end

      need = (int'(rows_cfg) * int'(grp_pct) + 50) / 100;
      limit = (int'(rows_cfg) * int'(oth_pct) + 50) / 100;
      pass = total != 0 && win_count >= need && other_sum <= limit;

      for (int k = 0; k < rows_seen; k++) begin
        e.row_index = 6'(k);
        e.marked = (pass && row_letter[k] < LETTERS) ? win_mask[row_letter[k]] : 1'b0;
        e.last = (k + 1 == rows_seen);
        if (e.marked) marked_rows++;
        expected_marks.push_back(e);
      end

      columns++;
      foreach (grp_count[k]) begin
        grp_count[k] = '0;
        oth_count[k] = '0;
      end
      rows_seen = 0;
    endfunction

    function void complain(string msg);
      mismatches++;
      if (mismatches <= SHOW_LIMIT) $display("mismatch: %s", msg);
    endfunction

    function void check_mark(out_beat_t got);
      out_beat_t want;
      marks_checked++;
      if (expected_marks.size() == 0) begin
        complain($sformatf("result beat %0d arrived with nothing expected (row %0d mark %0b last %0b)",
                           marks_checked, got.row_index, got.marked, got.last));
        return;
      end
      want = expected_marks.pop_front();
      if (got.row_index !== want.row_index)
        complain($sformatf("beat %0d row_index expected %0d got %0d",
                           marks_checked, want.row_index, got.row_index));
      if (got.marked !== want.marked)
        complain($sformatf("beat %0d (row %0d) marked expected %0b got %0b",
                           marks_checked, want.row_index, want.marked, got.marked));
      if (got.last !== want.last)
        complain($sformatf("beat %0d (row %0d) last expected %0b got %0b",
                           marks_checked, want.row_index, want.last, got.last));
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench of the group conserved residue marker unit.
module tb;
  import gcrm_pkg::*;
  import gcrm_mark_check_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES   = 200;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [CFG_IDX_W-1:0] REG_PAST_END = REG_SIM_SET_MASK + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX  = '1;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_beat_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mark_scoreboard marks;
  int             send_idle;
  int             recv_idle;
  bit             long_hold;
  logic [25:0]    cur_mask;
  int             settings;
  int             quiet_cycles;

  group_conserved_residue_marker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random backpressure, or one long hold-off when asked for.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) marks.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) marks.note_residue(in_data);
      if (out_valid && out_ready) marks.check_mark(out_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
               quiet_cycles, marks.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Valid stays up across back-to-back beats; it only drops during an idle gap.
  task automatic send_residue(input in_beat_t b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes every register, with junk in the unused upper data bits, then pokes
  // two indexes past the end of the register map.
  task automatic configure(input logic [6:0] rows, input logic [6:0] gpct,
                           input logic [6:0] opct, input logic sen, input logic [25:0] mask);
    logic [31:0] junk;
    junk = $urandom;
    put_reg(REG_GROUP_ROWS, {junk[18:0], rows});
    put_reg(REG_GROUP_LEVEL_PCT, {junk[24:6], gpct});
    put_reg(REG_OUT_LEVEL_PCT, {junk[31:13], opct});
    put_reg(REG_SIM_ENABLE, {junk[25:1], sen});
    put_reg(REG_SIM_SET_MASK, mask);
    put_reg(REG_PAST_END, 26'($urandom));
    put_reg(REG_TOP_IDX, 26'($urandom));
    cfg_valid <= 1'b0;
    cur_mask = mask;
    settings++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (marks.pending() != 0) @(posedge clk);
    // A column with no group rows still runs its scan with nothing to show for it.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly the lead letter; otherwise a random letter, a raw byte, or a
  // member of the current similarity set. Letters come in either case.
  function automatic logic [7:0] make_residue(input int lead, input int purity);
    int r;
    int k;
    r = $urandom_range(99);
    k = lead;
    if (r >= purity) begin
      case (r % 4)
        0, 1: k = $urandom_range(25);
        2: return 8'($urandom_range(255));
        default: begin
          for (int t = 0; t < 8; t++) begin
            k = $urandom_range(25);
            if (cur_mask[k]) break;
          end
        end
      endcase
    end
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(k);
  endfunction

  task automatic send_column(input int ng, input int no, input int lead, input int purity);
    in_beat_t b;
    int       left_g;
    int       left_o;
    left_g = ng;
    left_o = no;
    while (left_g + left_o > 0) begin
      if (left_o == 0 || (left_g > 0 && $urandom_range(left_g + left_o - 1) < left_g)) begin
        b.in_group = 1'b1;
        b.residue = make_residue(lead, purity);
        left_g--;
      end else begin
        b.in_group = 1'b0;
        b.residue = make_residue(lead, 15);
        left_o--;
      end
      b.column_end = (left_g + left_o == 0);
      send_residue(b);
    end
  endtask

  // One column spelled out: g marks a group row, anything else another row.
  task automatic send_text(input string res, input string grp);
    in_beat_t b;
    for (int i = 0; i < res.len(); i++) begin
      b.residue = res[i];
      b.in_group = (grp[i] == "g");
      b.column_end = (i == res.len() - 1);
      send_residue(b);
    end
  endtask

  task automatic run_columns(input int target);
    int sent;
    int ng;
    int no;
    sent = 0;
    while (sent < target) begin
      ng = $urandom_range(9);
      no = $urandom_range(4);
      if (ng + no == 0) no = 1;
      send_column(ng, no, $urandom_range(25),
                  ($urandom_range(9) == 0) ? 0 : $urandom_range(100, 40));
      sent += ng + no;
    end
  endtask

  task automatic pick_setup(input int kind);
    case (kind)
      1: configure(7'd0, 7'd0, 7'd0, 1'b0, '0);
      3: configure(7'd127, 7'd127, 7'd127, 1'b1, '1);
      default: configure(7'($urandom_range(10, 1)), 7'($urandom_range(100)),
                         7'($urandom_range(100)), 1'($urandom_range(1)),
                         26'($urandom & $urandom));
    endcase
  endtask

  initial begin
    marks = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_GROUP_ROWS;
    cfg_data = '0;
    send_idle = 0;
    recv_idle = 0;
    long_hold = 1'b0;
    cur_mask = '0;
    settings = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Four group rows: the winner needs two, and one hit in other rows is tolerated.
    configure(7'd4, 7'd50, 7'd25, 1'b0, 26'h1C);
    send_text("AaBz", "gggo");
    send_text("ZzzZ", "ggoo");
    send_residue(in_beat_t'{residue: 8'h00, in_group: 1'b1, column_end: 1'b0});
    send_residue(in_beat_t'{residue: 8'hFF, in_group: 1'b1, column_end: 1'b0});
    send_residue(in_beat_t'{residue: "[", in_group: 1'b1, column_end: 1'b0});
    send_residue(in_beat_t'{residue: 8'h80, in_group: 1'b0, column_end: 1'b1});
    send_text("Mm", "oo");
    send_text("cDdC", "gggg");
    wait_drained();
    configure(7'd4, 7'd50, 7'd25, 1'b1, 26'h1C);
    send_text("CDAAe", "ggggg");
    send_text("cdaa", "gggg");

    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 14 : (p == 1) ? 86 : 0;
      recv_idle = (p == 0) ? 86 : (p == 1) ? 14 : 0;
      for (int s = 0; s < 2; s++) begin
        wait_drained();
        pick_setup(p * 2 + s);
        if (p == 2 && s == 0) long_hold = 1'b1;
        run_columns(12);
      end
    end

    // Other-row count of one letter runs past saturation; the limit sits just above it.
    wait_drained();
    configure(7'd127, 7'd0, 7'd101, 1'b0, '0);
    repeat (129) send_residue(in_beat_t'{residue: make_residue(16, 100), in_group: 1'b0,
                                         column_end: 1'b0});
    send_residue(in_beat_t'{residue: "Q", in_group: 1'b1, column_end: 1'b1});

    // More group rows than the block keeps; only the first ones count and report.
    wait_drained();
    configure(7'd64, 7'd100, 7'd100, 1'b1, '1);
    send_column(67, 3, $urandom_range(25), 100);

    wait_drained();
    $display("Covered %0d residues in %0d columns under %0d register settings,",
             marks.residues, marks.columns, settings);
    $display("with %0d row results checked, %0d of them marked.",
             marks.marks_checked, marks.marked_rows);
    if (marks.pending() != 0) $display("%0d expected row results never arrived", marks.pending());
    if (marks.mismatches == 0 && marks.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
